// ===== rtl/assert_macros.svh =====
// Assertion macros for the BC5 decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset
`define BC5_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset
`define BC5_ASSERT_NEVER(label, expr, msg) \
  `BC5_ASSERT(label, !(expr), msg)

`endif

// ===== rtl/bc5_pkg.sv =====
// Package with types, constants and helpers for the BC5 block decoder
`timescale 1ns / 1ps
`default_nettype none

package bc5_pkg;

  localparam int NUM_TEXELS  = 16;
  localparam int NUM_PAL     = 8;
  localparam int NUM_INTERP  = 6;
  localparam int IDX_BITS    = 3;
  localparam int IDX_W       = NUM_TEXELS * IDX_BITS;
  localparam int EW          = 10;   // endpoint value, -128..255
  localparam int SW          = 13;   // weighted endpoint sum
  localparam int XW          = 12;   // biased numerator, always positive
  localparam int RW          = 13;   // reciprocal constant
  localparam int PW          = XW + RW;
  localparam int QW          = 9;    // quotient, 0..383
  localparam int RECIP_SHIFT = 15;

  // floor(x/7) and floor(x/5) by multiply and shift, exact for x below 4096
  localparam logic [RW-1:0] RECIP7 = RW'(((1 << RECIP_SHIFT) + 6) / 7);
  localparam logic [RW-1:0] RECIP5 = RW'(((1 << RECIP_SHIFT) + 4) / 5);

  // Biases fold the +0.5 rounding and a +128 shift (keeps numerators positive)
  localparam logic [XW-1:0] BIAS7 = XW'(899);
  localparam logic [XW-1:0] BIAS5 = XW'(642);

  localparam logic [7:0] SIGN_FLIP = 8'h80;
  localparam logic [7:0] LIMIT_LO  = 8'h00;
  localparam logic [7:0] LIMIT_HI  = 8'hFF;
  localparam logic [7:0] BLUE_SGN  = 8'h80;
  localparam logic [7:0] BLUE_UNS  = 8'h00;
  localparam logic [7:0] ALPHA     = 8'hFF;
  localparam logic [3:0] TEXEL_LAST = 4'(NUM_TEXELS - 1);

  typedef struct packed {
    logic [7:0]       red_end_a;
    logic [7:0]       red_end_b;
    logic [IDX_W-1:0] red_indices;
    logic [7:0]       green_end_a;
    logic [7:0]       green_end_b;
    logic [IDX_W-1:0] green_indices;
  } in_req_t;

  typedef struct packed {
    logic [3:0] texel_number;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_texel;
  } out_req_t;

  // Palette already in output encoding (offset applied)
  typedef logic [NUM_PAL-1:0][7:0] pal_t;

  typedef struct packed {
    logic adv1;
    logic adv2;
  } pipe_ctl_t;

  // Biased numerator a*wa + b*wb + bias, known to fit XW bits unsigned
  function automatic logic [XW-1:0] interp_x(
    input logic signed [EW-1:0] a,
    input logic signed [EW-1:0] b,
    input logic [2:0]           wa,
    input logic [2:0]           wb,
    input logic [XW-1:0]        bias
  );
    logic signed [SW-1:0] a13;
    logic signed [SW-1:0] b13;
    logic signed [SW-1:0] s;
    a13 = SW'(a);
    b13 = SW'(b);
    s = a13 * signed'({{(SW-3){1'b0}}, wa}) + b13 * signed'({{(SW-3){1'b0}}, wb})
        + signed'({{(SW-XW){1'b0}}, bias});
    return s[XW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bc5_pal_lane.sv =====
// One channel lane: two-stage palette builder with its index word carried along
`timescale 1ns / 1ps
`default_nettype none

module bc5_pal_lane
  import bc5_pkg::*;
(
  input  wire logic             clk,
  input  wire pipe_ctl_t        ctl,
  input  wire logic             sgn,
  input  wire logic [7:0]       end_a,
  input  wire logic [7:0]       end_b,
  input  wire logic [IDX_W-1:0] indices,
  output pal_t                  pal,
  output logic [IDX_W-1:0]      idx_out
);

  logic signed [EW-1:0] e0;
  logic signed [EW-1:0] e1;

  // stage 1: numerators
  logic [XW-1:0]    x_nxt [NUM_INTERP];
  logic [XW-1:0]    x_r   [NUM_INTERP];
  logic             gt_nxt, gt_r;
  logic [7:0]       a_r, b_r;
  logic [IDX_W-1:0] idx1_r;

  // stage 2: quotients
  logic [PW-1:0]    prod  [NUM_INTERP];
  logic [QW-1:0]    q_nxt [NUM_INTERP];
  logic [QW-1:0]    q_r   [NUM_INTERP];
  logic             gt2_r;
  logic [7:0]       a2_r, b2_r;
  logic [IDX_W-1:0] idx2_r;

  logic [7:0] flip_e, flip_q;

  always_comb begin
    e0 = sgn ? signed'({{(EW-8){end_a[7]}}, end_a}) : signed'({{(EW-8){1'b0}}, end_a});
    e1 = sgn ? signed'({{(EW-8){end_b[7]}}, end_b}) : signed'({{(EW-8){1'b0}}, end_b});
    gt_nxt = (e0 > e1);
    for (int j = 0; j < NUM_INTERP; j++) begin
      if (gt_nxt) begin
        x_nxt[j] = interp_x(e0, e1, 3'(6 - j), 3'(j + 1), BIAS7);
      end else if (j < 4) begin
        x_nxt[j] = interp_x(e0, e1, 3'(4 - j), 3'(j + 1), BIAS5);
      end else begin
        x_nxt[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      x_r    <= x_nxt;
      gt_r   <= gt_nxt;
      a_r    <= end_a;
      b_r    <= end_b;
      idx1_r <= indices;
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_INTERP; j++) begin
      prod[j]  = PW'(x_r[j]) * PW'(gt_r ? RECIP7 : RECIP5);
      q_nxt[j] = prod[j][QW+RECIP_SHIFT-1:RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      q_r    <= q_nxt;
      gt2_r  <= gt_r;
      a2_r   <= a_r;
      b2_r   <= b_r;
      idx2_r <= idx1_r;
    end
  end

  // quotients carry a +128 shift; endpoints are raw bytes
  always_comb begin
    flip_e = sgn ? SIGN_FLIP : 8'h00;
    flip_q = sgn ? 8'h00 : SIGN_FLIP;
    pal[0] = a2_r ^ flip_e;
    pal[1] = b2_r ^ flip_e;
    for (int j = 0; j < NUM_INTERP; j++) begin
      if (gt2_r || j < 4) begin
        pal[j + 2] = q_r[j][7:0] ^ flip_q;
      end else if (j == 4) begin
        pal[j + 2] = LIMIT_LO;
      end else begin
        pal[j + 2] = LIMIT_HI;
      end
    end
    idx_out = idx2_r;
  end

endmodule

`default_nettype wire

// ===== rtl/bc5_texel_merge.sv =====
// Merge stage: holds both lane palettes and emits sixteen texels per block
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bc5_texel_merge
  import bc5_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             sgn,
  input  wire logic             ld_valid,
  output logic                  ld_ready,
  input  wire pal_t             red_pal,
  input  wire pal_t             green_pal,
  input  wire logic [IDX_W-1:0] red_idx,
  input  wire logic [IDX_W-1:0] green_idx,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_req_t              out_data
);

  logic             blk_valid_r, blk_valid_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  pal_t             red_pal_r, red_pal_nxt;
  pal_t             green_pal_r, green_pal_nxt;
  logic [IDX_W-1:0] red_idx_r, red_idx_nxt;
  logic [IDX_W-1:0] green_idx_r, green_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_req_t         out_data_r, out_data_nxt;

  logic emit_fire;
  logic last;
  logic ld_fire;

  always_comb begin
    emit_fire = blk_valid_r && (!out_valid_r || out_ready);
    last      = (cnt_r == TEXEL_LAST);
    ld_ready  = !blk_valid_r || (emit_fire && last);
    ld_fire   = ld_valid && ld_ready;
  end

  always_comb begin
    blk_valid_nxt = blk_valid_r;
    cnt_nxt       = cnt_r;
    red_pal_nxt   = red_pal_r;
    green_pal_nxt = green_pal_r;
    red_idx_nxt   = red_idx_r;
    green_idx_nxt = green_idx_r;
    out_valid_nxt = emit_fire || (out_valid_r && !out_ready);
    out_data_nxt  = out_data_r;

    if (emit_fire) begin
      out_data_nxt.texel_number = cnt_r;
      out_data_nxt.red_out      = red_pal_r[red_idx_r[IDX_BITS-1:0]];
      out_data_nxt.green_out    = green_pal_r[green_idx_r[IDX_BITS-1:0]];
      out_data_nxt.blue_out     = sgn ? BLUE_SGN : BLUE_UNS;
      out_data_nxt.alpha_out    = ALPHA;
      out_data_nxt.last_texel   = last;
      // advance to the next texel's indices
      cnt_nxt       = cnt_r + 4'd1;
      red_idx_nxt   = red_idx_r >> IDX_BITS;
      green_idx_nxt = green_idx_r >> IDX_BITS;
      if (last) begin
        blk_valid_nxt = 1'b0;
      end
    end

    if (ld_fire) begin
      blk_valid_nxt = 1'b1;
      cnt_nxt       = '0;
      red_pal_nxt   = red_pal;
      green_pal_nxt = green_pal;
      red_idx_nxt   = red_idx;
      green_idx_nxt = green_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      blk_valid_r <= blk_valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_pal_r   <= red_pal_nxt;
    green_pal_r <= green_pal_nxt;
    red_idx_r   <= red_idx_nxt;
    green_idx_r <= green_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BC5_ASSERT(a_last_flag, out_valid_r |-> (out_data_r.last_texel == (out_data_r.texel_number == TEXEL_LAST)), "last_texel disagrees with texel_number")
  `BC5_ASSERT(a_load_restart, ld_fire |=> (blk_valid_r && cnt_r == 4'd0), "block load did not restart at texel zero")
  `BC5_ASSERT_NEVER(a_drain_empty, $past(emit_fire && last && !ld_valid) && blk_valid_r && rst_n && $past(rst_n), "block still held after its last texel")

endmodule

`default_nettype wire

// ===== rtl/bc5_block_decoder_core.sv =====
// Top level of the BC5 block decoder: config register, lane control and merge
`timescale 1ns / 1ps
`default_nettype none

// Takes one 16-byte BC5 block per request on in_* and returns sixteen texel
// requests on out_* in row-major order, the last one flagged by last_texel.
// The red and green palettes are built side by side in two lanes, each a
// two-stage pipeline (weighted sums, then a reciprocal multiply), and a merge
// stage picks one texel per cycle while out_ready allows. The result port
// carries a single texel at a time; the next block is taken and built while
// the current one drains. The first texel of a block is presented once the
// block has passed both lane stages, the merge load and the output register.
// cfg_wdata sets signed mode and may only change while no block is in flight.

module bc5_block_decoder_core
  import bc5_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_req_t      out_data
);

  logic sgn_r, sgn_nxt;
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;

  pipe_ctl_t ctl;
  logic      ld_ready;
  logic      adv_load;

  pal_t             red_pal, green_pal;
  logic [IDX_W-1:0] red_idx, green_idx;

  always_comb begin
    sgn_nxt  = cfg_we ? cfg_wdata : sgn_r;
    adv_load = v2_r && ld_ready;
    ctl.adv2 = v1_r && (!v2_r || adv_load);
    in_ready = !v1_r || ctl.adv2;
    ctl.adv1 = in_valid && in_ready;
    v1_nxt   = ctl.adv1 || (v1_r && !ctl.adv2);
    v2_nxt   = ctl.adv2 || (v2_r && !adv_load);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sgn_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      sgn_r <= sgn_nxt;
      v1_r  <= v1_nxt;
      v2_r  <= v2_nxt;
    end
  end

  bc5_pal_lane u_red_lane (
    .clk     (clk),
    .ctl     (ctl),
    .sgn     (sgn_r),
    .end_a   (in_data.red_end_a),
    .end_b   (in_data.red_end_b),
    .indices (in_data.red_indices),
    .pal     (red_pal),
    .idx_out (red_idx)
  );

  bc5_pal_lane u_green_lane (
    .clk     (clk),
    .ctl     (ctl),
    .sgn     (sgn_r),
    .end_a   (in_data.green_end_a),
    .end_b   (in_data.green_end_b),
    .indices (in_data.green_indices),
    .pal     (green_pal),
    .idx_out (green_idx)
  );

  bc5_texel_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .sgn       (sgn_r),
    .ld_valid  (v2_r),
    .ld_ready  (ld_ready),
    .red_pal   (red_pal),
    .green_pal (green_pal),
    .red_idx   (red_idx),
    .green_idx (green_idx),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
